@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the cuckoo hash core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define CHT_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define CHT_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/cht_pkg.sv @@
// shared types, codes and hash constants of the cuckoo hash core
`default_nettype none

package cht_pkg;

    localparam int KEY_W     = 32;
    localparam int DATA_W    = 32;
    localparam int MODE_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int KICK_W    = 8;
    localparam int OCC_W     = 12;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE   = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISS    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_UPDATED = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd3;

    localparam logic [KEY_W-1:0] HASH_C1     = 32'h85ebca6b;
    localparam logic [KEY_W-1:0] HASH_C2     = 32'hc2b2ae35;
    localparam logic [KEY_W-1:0] HASH_GOLDEN = 32'h9e3779b9;
    localparam logic [KEY_W-1:0] HASH_MIX    = 32'h045d9f3b;

    localparam logic [KICK_W-1:0] KICK_CAP_RESET = 8'd32;
    localparam logic              REG_KICK_CAP   = 1'b0;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [DATA_W-1:0]   read_value;
        logic [KEY_W-1:0]    spill_key;
        logic [DATA_W-1:0]   spill_value;
        logic [KICK_W-1:0]   kicks_used;
        logic [OCC_W-1:0]    occupancy;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH_A,
        ST_HASH_B,
        ST_READ,
        ST_EVAL,
        ST_KHASH_A,
        ST_KHASH_B,
        ST_KREAD,
        ST_KEVAL,
        ST_FINISH
    } cht_state_t;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_UPD1,
        ACT_UPD2,
        ACT_INS1,
        ACT_INS2,
        ACT_KICK,
        ACT_PLACE,
        ACT_FULL,
        ACT_LOOK,
        ACT_DEL,
        ACT_NOP
    } cht_act_t;

    typedef struct packed {
        logic     clear_step;
        logic     load_in;
        logic     latch_idx;
        cht_act_t act;
        logic     out_load;
    } cht_cmd_t;

    typedef struct packed {
        logic              clear_done;
        logic [MODE_W-1:0] mode;
        logic              hit1;
        logic              hit2;
        logic              v1;
        logic              v2;
        logic              side_valid;
        logic              kick_limit;
        logic              kick_zero;
        logic              out_free;
    } cht_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/cht_if.sv @@
// valid/ready channel interfaces for request and response transactions
`default_nettype none

interface cht_in_if;
    logic               valid;
    logic               ready;
    cht_pkg::in_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cht_out_if;
    logic               valid;
    logic               ready;
    cht_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/cht_ram.sv @@
// generic single-write, single-read ram with registered read data
`default_nettype none

module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/core/cht_ctrl.sv @@
// sequencing state machine of the cuckoo hash core
`default_nettype none

module cht_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire cht_pkg::cht_stat_t stat,
    output cht_pkg::cht_cmd_t      cmd
);

    cht_pkg::cht_state_t state_reg;
    cht_pkg::cht_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cht_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        cmd.clear_step = 1'b0;
        cmd.load_in    = 1'b0;
        cmd.latch_idx  = 1'b0;
        cmd.act        = cht_pkg::ACT_NONE;
        cmd.out_load   = 1'b0;
        case (state_reg)
            cht_pkg::ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_done)
                begin
                    state_next = cht_pkg::ST_IDLE;
                end
            end
            cht_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = cht_pkg::ST_HASH_A;
                end
            end
            cht_pkg::ST_HASH_A:
            begin
                state_next = cht_pkg::ST_HASH_B;
            end
            cht_pkg::ST_HASH_B:
            begin
                state_next = cht_pkg::ST_READ;
            end
            cht_pkg::ST_READ:
            begin
                cmd.latch_idx = 1'b1;
                state_next    = cht_pkg::ST_EVAL;
            end
            cht_pkg::ST_EVAL:
            begin
                state_next = cht_pkg::ST_FINISH;
                case (stat.mode)
                    cht_pkg::MODE_INSERT:
                    begin
                        if (stat.hit1)
                        begin
                            cmd.act = cht_pkg::ACT_UPD1;
                        end
                        else if (stat.hit2)
                        begin
                            cmd.act = cht_pkg::ACT_UPD2;
                        end
                        else if (!stat.v1)
                        begin
                            cmd.act = cht_pkg::ACT_INS1;
                        end
                        else if (!stat.v2)
                        begin
                            cmd.act = cht_pkg::ACT_INS2;
                        end
                        else if (stat.kick_zero)
                        begin
                            cmd.act = cht_pkg::ACT_FULL;
                        end
                        else
                        begin
                            cmd.act    = cht_pkg::ACT_KICK;
                            state_next = cht_pkg::ST_KHASH_A;
                        end
                    end
                    cht_pkg::MODE_LOOKUP:
                    begin
                        cmd.act = cht_pkg::ACT_LOOK;
                    end
                    cht_pkg::MODE_REMOVE:
                    begin
                        cmd.act = cht_pkg::ACT_DEL;
                    end
                    default:
                    begin
                        cmd.act = cht_pkg::ACT_NOP;
                    end
                endcase
            end
            cht_pkg::ST_KHASH_A:
            begin
                state_next = cht_pkg::ST_KHASH_B;
            end
            cht_pkg::ST_KHASH_B:
            begin
                state_next = cht_pkg::ST_KREAD;
            end
            cht_pkg::ST_KREAD:
            begin
                cmd.latch_idx = 1'b1;
                state_next    = cht_pkg::ST_KEVAL;
            end
            cht_pkg::ST_KEVAL:
            begin
                state_next = cht_pkg::ST_FINISH;
                if (!stat.side_valid)
                begin
                    cmd.act = cht_pkg::ACT_PLACE;
                end
                else if (stat.kick_limit)
                begin
                    cmd.act = cht_pkg::ACT_FULL;
                end
                else
                begin
                    cmd.act    = cht_pkg::ACT_KICK;
                    state_next = cht_pkg::ST_KHASH_A;
                end
            end
            cht_pkg::ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = cht_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cht_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/cht_datapath.sv @@
// hash pipeline, two slot tables, carry registers and result register
`default_nettype none

module cht_datapath #(
    parameter int TABLE_DEPTH = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire cht_pkg::cht_cmd_t           cmd,
    output cht_pkg::cht_stat_t               stat,
    input  wire cht_pkg::in_item_t           in_data,
    input  wire logic [cht_pkg::KICK_W-1:0]  kick_cap,
    input  wire logic                        out_ready,
    output logic                             out_valid,
    output cht_pkg::out_item_t               out_data
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int FW = $clog2(2 * TABLE_DEPTH + 1);
    localparam int WW = 1 + cht_pkg::KEY_W + VALUE_WIDTH;

    // control registers
    logic [IW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic          out_valid_reg, out_valid_next;

    // payload registers
    logic [cht_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic [cht_pkg::KEY_W-1:0]  ck_reg, ck_next;
    logic [VALUE_WIDTH-1:0]     cv_reg, cv_next;
    logic [cht_pkg::KEY_W-1:0]  hk_reg, hk_next;
    logic [cht_pkg::KEY_W-1:0]  a1_reg, a1_next, a2_reg, a2_next;
    logic [cht_pkg::KEY_W-1:0]  b1_reg, b1_next, b2_reg, b2_next;
    logic [IW-1:0]              h1_reg, h1_next, h2_reg, h2_next;
    logic                       side_reg, side_next;
    logic [cht_pkg::KICK_W-1:0] kick_reg, kick_next;
    cht_pkg::out_item_t         res_reg, res_next;
    cht_pkg::out_item_t         out_data_reg, out_data_next;

    // hash and table signals
    logic [cht_pkg::KEY_W-1:0] t2_sum, x1, x2, y1, y2, f1, f2;
    logic [IW-1:0]             idx1, idx2;
    logic                      we1, we2;
    logic [IW-1:0]             waddr1, waddr2;
    logic [WW-1:0]             wdata1, wdata2, rdata1, rdata2, carry_word;
    logic                      rd1_valid, rd2_valid, sd_valid, hit1, hit2;
    logic [cht_pkg::KEY_W-1:0] rd1_key, rd2_key, sd_key;
    logic [VALUE_WIDTH-1:0]    rd1_val, rd2_val, sd_val;

    // two-stage hash of hk_reg for both tables
    always_comb
    begin
        x1      = hk_reg ^ (hk_reg >> 16);
        a1_next = x1 * cht_pkg::HASH_C1;
        t2_sum  = hk_reg + cht_pkg::HASH_GOLDEN;
        x2      = t2_sum ^ (t2_sum >> 16);
        a2_next = x2 * cht_pkg::HASH_MIX;
        y1      = a1_reg ^ (a1_reg >> 13);
        b1_next = y1 * cht_pkg::HASH_C2;
        y2      = a2_reg ^ (a2_reg >> 16);
        b2_next = y2 * cht_pkg::HASH_MIX;
        f1      = b1_reg ^ (b1_reg >> 16);
        f2      = b2_reg ^ (b2_reg >> 16);
        idx1    = f1[IW-1:0];
        idx2    = f2[IW-1:0];
    end

    cht_ram #(
        .WIDTH (WW),
        .DEPTH (TABLE_DEPTH)
    ) u_table_one (
        .clk   (clk),
        .we    (we1),
        .waddr (waddr1),
        .wdata (wdata1),
        .raddr (idx1),
        .rdata (rdata1)
    );

    cht_ram #(
        .WIDTH (WW),
        .DEPTH (TABLE_DEPTH)
    ) u_table_two (
        .clk   (clk),
        .we    (we2),
        .waddr (waddr2),
        .wdata (wdata2),
        .raddr (idx2),
        .rdata (rdata2)
    );

    always_comb
    begin
        rd1_valid  = rdata1[WW-1];
        rd1_key    = rdata1[WW-2 -: cht_pkg::KEY_W];
        rd1_val    = rdata1[VALUE_WIDTH-1:0];
        rd2_valid  = rdata2[WW-1];
        rd2_key    = rdata2[WW-2 -: cht_pkg::KEY_W];
        rd2_val    = rdata2[VALUE_WIDTH-1:0];
        sd_valid   = side_reg ? rd2_valid : rd1_valid;
        sd_key     = side_reg ? rd2_key : rd1_key;
        sd_val     = side_reg ? rd2_val : rd1_val;
        hit1       = rd1_valid && (rd1_key == ck_reg);
        hit2       = rd2_valid && (rd2_key == ck_reg);
        carry_word = {1'b1, ck_reg, cv_reg};
    end

    always_comb
    begin
        stat.clear_done = (clr_cnt_reg == {IW{1'b1}});
        stat.mode       = mode_reg;
        stat.hit1       = hit1;
        stat.hit2       = hit2;
        stat.v1         = rd1_valid;
        stat.v2         = rd2_valid;
        stat.side_valid = sd_valid;
        stat.kick_limit = (kick_reg == kick_cap);
        stat.kick_zero  = (kick_cap == '0);
        stat.out_free   = !out_valid_reg || out_ready;
    end

    // table writes
    always_comb
    begin
        we1    = 1'b0;
        we2    = 1'b0;
        waddr1 = h1_reg;
        waddr2 = h2_reg;
        wdata1 = carry_word;
        wdata2 = carry_word;
        if (cmd.clear_step)
        begin
            we1    = 1'b1;
            we2    = 1'b1;
            waddr1 = clr_cnt_reg;
            waddr2 = clr_cnt_reg;
            wdata1 = '0;
            wdata2 = '0;
        end
        case (cmd.act)
            cht_pkg::ACT_UPD1, cht_pkg::ACT_INS1:
            begin
                we1 = 1'b1;
            end
            cht_pkg::ACT_UPD2, cht_pkg::ACT_INS2:
            begin
                we2 = 1'b1;
            end
            cht_pkg::ACT_KICK, cht_pkg::ACT_PLACE:
            begin
                we1 = !side_reg;
                we2 = side_reg;
            end
            cht_pkg::ACT_DEL:
            begin
                wdata1 = '0;
                wdata2 = '0;
                we1    = hit1;
                we2    = !hit1 && hit2;
            end
            default:
            begin
                we1 = we1;
            end
        endcase
    end

    // register updates
    always_comb
    begin
        clr_cnt_next   = clr_cnt_reg;
        fill_next      = fill_reg;
        out_valid_next = out_valid_reg;
        mode_next      = mode_reg;
        ck_next        = ck_reg;
        cv_next        = cv_reg;
        hk_next        = hk_reg;
        h1_next        = h1_reg;
        h2_next        = h2_reg;
        side_next      = side_reg;
        kick_next      = kick_reg;
        res_next       = res_reg;
        out_data_next  = out_data_reg;

        if (cmd.clear_step)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
        end
        if (cmd.load_in)
        begin
            mode_next = in_data.mode;
            ck_next   = in_data.key;
            cv_next   = VALUE_WIDTH'(in_data.value);
            hk_next   = in_data.key;
            side_next = 1'b0;
            kick_next = '0;
        end
        if (cmd.latch_idx)
        begin
            h1_next = idx1;
            h2_next = idx2;
        end

        case (cmd.act)
            cht_pkg::ACT_UPD1, cht_pkg::ACT_UPD2:
            begin
                res_next        = '0;
                res_next.status = cht_pkg::STATUS_UPDATED;
            end
            cht_pkg::ACT_INS1, cht_pkg::ACT_INS2, cht_pkg::ACT_PLACE:
            begin
                fill_next           = fill_reg + 1'b1;
                res_next            = '0;
                res_next.status     = cht_pkg::STATUS_DONE;
                res_next.kicks_used = kick_reg;
            end
            cht_pkg::ACT_KICK:
            begin
                ck_next   = sd_key;
                cv_next   = sd_val;
                hk_next   = sd_key;
                side_next = !side_reg;
                kick_next = kick_reg + 1'b1;
            end
            cht_pkg::ACT_FULL:
            begin
                res_next             = '0;
                res_next.status      = cht_pkg::STATUS_FULL;
                res_next.spill_key   = ck_reg;
                res_next.spill_value = cht_pkg::DATA_W'(cv_reg);
                res_next.kicks_used  = kick_reg;
            end
            cht_pkg::ACT_LOOK:
            begin
                res_next = '0;
                if (hit1)
                begin
                    res_next.found      = 1'b1;
                    res_next.read_value = cht_pkg::DATA_W'(rd1_val);
                end
                else if (hit2)
                begin
                    res_next.found      = 1'b1;
                    res_next.read_value = cht_pkg::DATA_W'(rd2_val);
                end
                else
                begin
                    res_next.status = cht_pkg::STATUS_MISS;
                end
            end
            cht_pkg::ACT_DEL:
            begin
                res_next = '0;
                if (hit1 || hit2)
                begin
                    fill_next      = fill_reg - 1'b1;
                    res_next.found = 1'b1;
                end
                else
                begin
                    res_next.status = cht_pkg::STATUS_MISS;
                end
            end
            cht_pkg::ACT_NOP:
            begin
                res_next = '0;
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase

        if (cmd.out_load)
        begin
            out_data_next           = res_reg;
            out_data_next.occupancy = cht_pkg::OCC_W'(fill_reg);
            out_valid_next          = 1'b1;
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_cnt_reg   <= clr_cnt_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        ck_reg       <= ck_next;
        cv_reg       <= cv_next;
        hk_reg       <= hk_next;
        a1_reg       <= a1_next;
        a2_reg       <= a2_next;
        b1_reg       <= b1_next;
        b2_reg       <= b2_next;
        h1_reg       <= h1_next;
        h2_reg       <= h2_next;
        side_reg     <= side_next;
        kick_reg     <= kick_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

@@ rtl/core/cuckoo_hash_table_engine_core.sv @@
// top level of the two-table cuckoo hash core
// request channel carries one transaction per operation: mode, key and value;
// response channel returns one transaction per request with status, found,
// read value, spilled entry, displacement count and occupancy.
// the displacement limit is written over the APB port at byte address 0;
// the user must write it only while idle; the core itself does not enforce it.
// after reset both tables are swept clean, one slot per cycle; request ready
// stays low until the sweep is done.
// one operation is handled at a time: a lookup, remove or plain insert passes
// from request transaction to response valid through the two-stage hash
// pipeline, the registered table read, the evaluate step and the result load;
// a new request is taken only once the previous result is in the output register.
// each displacement of an insert adds a rehash of the carried key through the
// hash pipeline, the read of the other table and its evaluation.
// the response sits in an output register; while the receiver stalls the
// core still takes the next request and works on it, and only waits before
// handing over the next response.
`default_nettype none

`include "assert_macros.svh"

module cuckoo_hash_table_engine_core #(
    parameter int TABLE_DEPTH = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    cht_in_if.sink                             request,
    cht_out_if.source                          response,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [cht_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [cht_pkg::PDATA_W-1:0]   pwdata,
    output logic      [cht_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready
);

    logic [cht_pkg::KICK_W-1:0] kick_cap_reg, kick_cap_next;
    logic                       cfg_write;
    cht_pkg::cht_cmd_t          cmd;
    cht_pkg::cht_stat_t         stat;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        kick_cap_next = kick_cap_reg;
        if (cfg_write && (paddr[cht_pkg::PADDR_W-1] == cht_pkg::REG_KICK_CAP))
        begin
            kick_cap_next = pwdata[cht_pkg::KICK_W-1:0];
        end
        if (paddr[cht_pkg::PADDR_W-1] == cht_pkg::REG_KICK_CAP)
        begin
            prdata = cht_pkg::PDATA_W'(kick_cap_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kick_cap_reg <= cht_pkg::KICK_CAP_RESET;
        end
        else
        begin
            kick_cap_reg <= kick_cap_next;
        end
    end

    cht_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .in_ready (request.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cht_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (request.data),
        .kick_cap  (kick_cap_reg),
        .out_ready (response.ready),
        .out_valid (response.valid),
        .out_data  (response.data)
    );

    `CHT_ASSERT_IMPL(a_full_uses_all_kicks, response.valid && (response.data.status == cht_pkg::STATUS_FULL), response.data.kicks_used == kick_cap_reg, "full response without all kicks used")
    `CHT_ASSERT_IMPL(a_found_means_done, response.valid && response.data.found, response.data.status == cht_pkg::STATUS_DONE, "found set on a non-done response")
    `CHT_ASSERT_NEXT(a_one_at_a_time, request.valid && request.ready, !request.ready, "request taken while an operation is in progress")

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// self-checking testbench for the two-table cuckoo hash core
`default_nettype none

module tb_top;

    localparam int DEPTH      = 1024;
    localparam int IDX_W      = 10;
    localparam int LIMIT      = 10000000;
    localparam int HOLD_LONG  = 400;
    localparam int POOL_SIZE  = 40;

    typedef struct {
        bit                  is_cfg;
        logic [7:0]          kicks;
        cht_pkg::in_item_t   item;
        bit                  typed;
        cht_pkg::out_item_t  exp;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [cht_pkg::PADDR_W-1:0] paddr;
    logic [cht_pkg::PDATA_W-1:0] pwdata;
    logic [cht_pkg::PDATA_W-1:0] prdata;
    logic pready;

    cht_in_if  req_if ();
    cht_out_if rsp_if ();

    cuckoo_hash_table_engine_core #(
        .TABLE_DEPTH (DEPTH),
        .VALUE_WIDTH (32)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req_if),
        .response (rsp_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // predictor state
    bit          occ_one [DEPTH];
    bit          occ_two [DEPTH];
    logic [31:0] tkey_one [DEPTH];
    logic [31:0] tval_one [DEPTH];
    logic [31:0] tkey_two [DEPTH];
    logic [31:0] tval_two [DEPTH];
    logic [11:0] slots_used;
    logic [7:0]  kick_limit;

    cht_pkg::out_item_t pending_resp [$];
    cht_pkg::out_item_t typed_resp [$];
    bit                 typed_flag [$];
    logic [31:0]        key_pool [$];
    logic [31:0]        recent_keys [$];
    stim_row_t          rows [$];

    int  errors;
    int  cycles;
    bit  quiet;
    bit  long_hold;
    int  send_idle_pct;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [IDX_W-1:0] murmur_idx(logic [31:0] k);
        logic [31:0] h;
        h = k;
        h = h ^ (h >> 16);
        h = h * cht_pkg::HASH_C1;
        h = h ^ (h >> 13);
        h = h * cht_pkg::HASH_C2;
        h = h ^ (h >> 16);
        return h[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] golden_idx(logic [31:0] k);
        logic [31:0] h;
        h = k + cht_pkg::HASH_GOLDEN;
        h = h ^ (h >> 16);
        h = h * cht_pkg::HASH_MIX;
        h = h ^ (h >> 16);
        h = h * cht_pkg::HASH_MIX;
        h = h ^ (h >> 16);
        return h[IDX_W-1:0];
    endfunction

    task automatic hash_step(input cht_pkg::in_item_t it, output cht_pkg::out_item_t r);
        logic [IDX_W-1:0] i1;
        logic [IDX_W-1:0] i2;
        logic [IDX_W-1:0] idx;
        logic [31:0] ck;
        logic [31:0] cv;
        logic [31:0] ek;
        logic [31:0] ev;
        bit hit1;
        bit hit2;
        bit in_one;
        bit placed;
        int k;
        r = '0;
        i1 = murmur_idx(it.key);
        i2 = golden_idx(it.key);
        hit1 = occ_one[i1] && tkey_one[i1] == it.key;
        hit2 = occ_two[i2] && tkey_two[i2] == it.key;
        case (it.mode)
            cht_pkg::MODE_INSERT:
            begin
                if (hit1)
                begin
                    tval_one[i1] = it.value;
                    r.status = cht_pkg::STATUS_UPDATED;
                end
                else if (hit2)
                begin
                    tval_two[i2] = it.value;
                    r.status = cht_pkg::STATUS_UPDATED;
                end
                else if (!occ_one[i1])
                begin
                    occ_one[i1] = 1'b1;
                    tkey_one[i1] = it.key;
                    tval_one[i1] = it.value;
                    slots_used++;
                end
                else if (!occ_two[i2])
                begin
                    occ_two[i2] = 1'b1;
                    tkey_two[i2] = it.key;
                    tval_two[i2] = it.value;
                    slots_used++;
                end
                else
                begin
                    ck = it.key;
                    cv = it.value;
                    idx = i1;
                    in_one = 1'b1;
                    placed = 1'b0;
                    for (k = 0; k < kick_limit && !placed; k++)
                    begin
                        if (in_one)
                        begin
                            ek = tkey_one[idx];
                            ev = tval_one[idx];
                            tkey_one[idx] = ck;
                            tval_one[idx] = cv;
                        end
                        else
                        begin
                            ek = tkey_two[idx];
                            ev = tval_two[idx];
                            tkey_two[idx] = ck;
                            tval_two[idx] = cv;
                        end
                        ck = ek;
                        cv = ev;
                        in_one = !in_one;
                        idx = in_one ? murmur_idx(ck) : golden_idx(ck);
                        if (in_one && !occ_one[idx])
                        begin
                            occ_one[idx] = 1'b1;
                            tkey_one[idx] = ck;
                            tval_one[idx] = cv;
                            placed = 1'b1;
                        end
                        else if (!in_one && !occ_two[idx])
                        begin
                            occ_two[idx] = 1'b1;
                            tkey_two[idx] = ck;
                            tval_two[idx] = cv;
                            placed = 1'b1;
                        end
                    end
                    r.kicks_used = k[7:0];
                    if (placed)
                    begin
                        slots_used++;
                    end
                    else
                    begin
                        r.status = cht_pkg::STATUS_FULL;
                        r.spill_key = ck;
                        r.spill_value = cv;
                    end
                end
            end
            cht_pkg::MODE_LOOKUP:
            begin
                if (hit1)
                begin
                    r.found = 1'b1;
                    r.read_value = tval_one[i1];
                end
                else if (hit2)
                begin
                    r.found = 1'b1;
                    r.read_value = tval_two[i2];
                end
                else
                begin
                    r.status = cht_pkg::STATUS_MISS;
                end
            end
            cht_pkg::MODE_REMOVE:
            begin
                if (hit1)
                begin
                    occ_one[i1] = 1'b0;
                    slots_used--;
                    r.found = 1'b1;
                end
                else if (hit2)
                begin
                    occ_two[i2] = 1'b0;
                    slots_used--;
                    r.found = 1'b1;
                end
                else
                begin
                    r.status = cht_pkg::STATUS_MISS;
                end
            end
            default:
            begin
            end
        endcase
        r.occupancy = slots_used;
    endtask

    // predict on every accepted request transaction
    always @(posedge clk)
    begin
        cht_pkg::out_item_t r;
        if (rst_n && req_if.valid && req_if.ready)
        begin
            hash_step(req_if.data, r);
            if (typed_flag.size() > 0 && typed_flag.pop_front())
            begin
                r = typed_resp.pop_front();
            end
            pending_resp.push_back(r);
        end
    end

    task automatic field_check(input string name, input logic [31:0] e, input logic [31:0] a);
        if (e !== a)
        begin
            $display("%0t mismatch %s: expected %0h actual %0h", $time, name, e, a);
            errors++;
        end
    endtask

    // compare every response transaction with the oldest expectation
    always @(posedge clk)
    begin
        cht_pkg::out_item_t e;
        cht_pkg::out_item_t a;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            a = rsp_if.data;
            if (pending_resp.size() == 0)
            begin
                $display("%0t unexpected response: expected none actual %0h", $time, a);
                errors++;
            end
            else
            begin
                e = pending_resp.pop_front();
                field_check("status", e.status, a.status);
                field_check("found", e.found, a.found);
                field_check("read_value", e.read_value, a.read_value);
                field_check("spill_key", e.spill_key, a.spill_key);
                field_check("spill_value", e.spill_value, a.spill_value);
                field_check("kicks_used", e.kicks_used, a.kicks_used);
                field_check("occupancy", e.occupancy, a.occupancy);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // response side: random stall bursts and one long hold-off
    initial
    begin
        int n;
        rsp_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                rsp_if.ready = 1'b0;
                repeat (HOLD_LONG - 1) @(negedge clk);
                long_hold = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 99) < 8)
            begin
                n = $urandom_range(1, 17);
                rsp_if.ready = 1'b0;
                repeat (n - 1) @(negedge clk);
            end
            else
            begin
                rsp_if.ready = 1'b1;
            end
        end
    end

    task automatic send_request(input cht_pkg::in_item_t it);
        int n;
        @(negedge clk);
        if (!quiet && $urandom_range(0, 99) < send_idle_pct)
        begin
            n = $urandom_range(1, 17);
            req_if.valid = 1'b0;
            repeat (n) @(negedge clk);
        end
        req_if.valid = 1'b1;
        req_if.data = it;
        @(posedge clk);
        while (!req_if.ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_kick_cap(input logic [7:0] v);
        @(negedge clk);
        req_if.valid = 1'b0;
        while (pending_resp.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {cht_pkg::REG_KICK_CAP, 2'b00};
        pwdata = {24'd0, v};
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        kick_limit = v;
    endtask

    function automatic cht_pkg::out_item_t typed_out(logic [1:0] st, logic fnd,
                                                     logic [31:0] rd, logic [11:0] occ);
        cht_pkg::out_item_t r;
        r = '0;
        r.status = st;
        r.found = fnd;
        r.read_value = rd;
        r.occupancy = occ;
        return r;
    endfunction

    function automatic stim_row_t op_row(logic [1:0] m, logic [31:0] k, logic [31:0] v);
        stim_row_t s;
        s = '{default: '0};
        s.item.mode = m;
        s.item.key = k;
        s.item.value = v;
        return s;
    endfunction

    function automatic stim_row_t cfg_row(logic [7:0] v);
        stim_row_t s;
        s = '{default: '0};
        s.is_cfg = 1'b1;
        s.kicks = v;
        return s;
    endfunction

    function automatic stim_row_t typed_row(logic [1:0] m, logic [31:0] k, logic [31:0] v,
                                            cht_pkg::out_item_t e);
        stim_row_t s;
        s = op_row(m, k, v);
        s.typed = 1'b1;
        s.exp = e;
        return s;
    endfunction

    task automatic run_item(input cht_pkg::in_item_t it, input bit typed,
                            input cht_pkg::out_item_t e);
        typed_flag.push_back(typed);
        typed_resp.push_back(e);
        if (!typed)
        begin
            typed_resp.pop_back();
        end
        send_request(it);
    endtask

    function automatic cht_pkg::in_item_t random_item();
        cht_pkg::in_item_t it;
        int r;
        r = $urandom_range(0, 99);
        it.mode = r < 45 ? cht_pkg::MODE_INSERT : r < 75 ? cht_pkg::MODE_LOOKUP :
                  r < 95 ? cht_pkg::MODE_REMOVE : cht_pkg::MODE_NONE;
        it.value = $urandom;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            it.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        else if (r < 80 && recent_keys.size() > 0)
        begin
            it.key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
        end
        else
        begin
            it.key = $urandom;
        end
        return it;
    endfunction

    initial
    begin
        logic [31:0] k;
        logic [7:0] phase_kicks [5];
        cht_pkg::in_item_t it;
        cht_pkg::out_item_t none;
        errors = 0;
        cycles = 0;
        quiet = 1'b0;
        long_hold = 1'b0;
        send_idle_pct = 20;
        none = '0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_if.valid = 1'b0;
        req_if.data = '0;
        slots_used = '0;
        kick_limit = cht_pkg::KICK_CAP_RESET;
        for (int i = 0; i < DEPTH; i++)
        begin
            occ_one[i] = 1'b0;
            occ_two[i] = 1'b0;
        end

        // keys crowded into a few slots of each table to force displacement
        while (key_pool.size() < POOL_SIZE)
        begin
            k = $urandom;
            if (murmur_idx(k) < 16 && golden_idx(k) < 8)
            begin
                key_pool.push_back(k);
            end
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        rows.push_back(typed_row(cht_pkg::MODE_LOOKUP, 32'h0, 32'h0,
                                 typed_out(cht_pkg::STATUS_MISS, 1'b0, 32'h0, 12'd0)));
        rows.push_back(typed_row(cht_pkg::MODE_INSERT, 32'h0, 32'h0,
                                 typed_out(cht_pkg::STATUS_DONE, 1'b0, 32'h0, 12'd1)));
        rows.push_back(typed_row(cht_pkg::MODE_LOOKUP, 32'h0, 32'h5,
                                 typed_out(cht_pkg::STATUS_DONE, 1'b1, 32'h0, 12'd1)));
        rows.push_back(typed_row(cht_pkg::MODE_INSERT, 32'h0, 32'hffffffff,
                                 typed_out(cht_pkg::STATUS_UPDATED, 1'b0, 32'h0, 12'd1)));
        rows.push_back(typed_row(cht_pkg::MODE_LOOKUP, 32'h0, 32'h0,
                                 typed_out(cht_pkg::STATUS_DONE, 1'b1, 32'hffffffff, 12'd1)));
        rows.push_back(typed_row(cht_pkg::MODE_REMOVE, 32'h0, 32'h0,
                                 typed_out(cht_pkg::STATUS_DONE, 1'b1, 32'h0, 12'd0)));
        rows.push_back(typed_row(cht_pkg::MODE_REMOVE, 32'h0, 32'h0,
                                 typed_out(cht_pkg::STATUS_MISS, 1'b0, 32'h0, 12'd0)));
        rows.push_back(typed_row(cht_pkg::MODE_NONE, 32'hffffffff, 32'hffffffff,
                                 typed_out(cht_pkg::STATUS_DONE, 1'b0, 32'h0, 12'd0)));
        rows.push_back(op_row(cht_pkg::MODE_INSERT, 32'hffffffff, 32'hffffffff));
        rows.push_back(op_row(cht_pkg::MODE_LOOKUP, 32'hffffffff, 32'h0));
        // zero kick limit: both slots taken spills the new entry
        rows.push_back(cfg_row(8'd0));
        for (int i = 0; i < 6; i++)
        begin
            rows.push_back(op_row(cht_pkg::MODE_INSERT, key_pool[i], ~key_pool[i]));
        end
        rows.push_back(cfg_row(8'd255));
        for (int i = 6; i < 14; i++)
        begin
            rows.push_back(op_row(cht_pkg::MODE_INSERT, key_pool[i],
                                  key_pool[i] ^ 32'h5a5a5a5a));
        end
        rows.push_back(op_row(cht_pkg::MODE_REMOVE, key_pool[7], 32'h0));

        foreach (rows[i])
        begin
            if (rows[i].is_cfg)
            begin
                write_kick_cap(rows[i].kicks);
            end
            else
            begin
                run_item(rows[i].item, rows[i].typed, rows[i].exp);
            end
        end

        phase_kicks[0] = 8'd32;
        phase_kicks[1] = 8'd1;
        phase_kicks[2] = 8'd255;
        phase_kicks[3] = 8'($urandom_range(2, 254));
        phase_kicks[4] = 8'd32;
        for (int p = 0; p < 5; p++)
        begin
            write_kick_cap(phase_kicks[p]);
            quiet = (p == 4);
            for (int i = 0; i < 240; i++)
            begin
                if (i % 40 == 0)
                begin
                    send_idle_pct = $urandom_range(0, 1) ? 0 : $urandom_range(5, 40);
                end
                if (p == 1 && i == 100)
                begin
                    long_hold = 1'b1;
                end
                it = random_item();
                if (it.mode == cht_pkg::MODE_INSERT && recent_keys.size() < 64)
                begin
                    recent_keys.push_back(it.key);
                end
                run_item(it, 1'b0, none);
            end
        end

        @(negedge clk);
        req_if.valid = 1'b0;
        while (pending_resp.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (50) @(negedge clk);
        if (errors == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
